/* src/mwe_pkg.sv */
// ----------------------------------------------------------------------------
// mwe_pkg
// shared types and constants for the microwire x8 eeprom command model
// ----------------------------------------------------------------------------
package mwe_pkg;

   localparam int WORDS_DEFAULT     = 128;
   localparam int WORD_BITS_DEFAULT = 8;

   localparam int OPC_W    = 3;
   localparam int ADDR_W   = 8;
   localparam int DATA_W   = 8;
   localparam int STATUS_W = 2;

   typedef enum logic [OPC_W-1:0] {
      OP_READ      = 3'd0,
      OP_WRITE     = 3'd1,
      OP_ERASE     = 3'd2,
      OP_ERASE_ALL = 3'd3,
      OP_WRITE_ALL = 3'd4,
      OP_ENABLE    = 3'd5,
      OP_DISABLE   = 3'd6
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_DISABLED = 2'd1,
      ST_RANGE    = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_EXEC  = 5'b00100,
      S_FILL  = 5'b01000,
      S_POST  = 5'b10000
   } state_type;

endpackage

/* src/microwire_eeprom_x8_top.sv */
// ----------------------------------------------------------------------------
// microwire_eeprom_x8_top
// command-level model of a microwire serial eeprom, x8 organisation
// ----------------------------------------------------------------------------
// Commands arrive one word at a time on the req_ stream (opcode, address,
// data); each gives exactly one result word on the rsp_ stream (read data,
// status). csr_wr_en / csr_wr_data set the auto-enable bit.
// Read, write, erase, enable, disable and unused opcodes: the accepting
// edge issues the store read; in the execute state, once the result slot
// is free, the write is done and the result register loaded. Erase-all and
// write-all sweep the store one word a cycle through the single write
// port, then wait in the post state to load their result. req_tready is
// high only while the sequencer is idle, so a new command is taken only
// once the previous one has left the execute, fill and post states.
// After reset the write-enable latch is off, auto-enable is on, and a
// clearing pass writes all ones to every word with req_tready low. The
// result register frees the input side: a command can be taken while a
// result waits, but the next result is held back until rsp_tready takes
// the waiting one.
// ----------------------------------------------------------------------------
module microwire_eeprom_x8_top #(
   parameter int WORDS     = mwe_pkg::WORDS_DEFAULT,
   parameter int WORD_BITS = mwe_pkg::WORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // opcode[2:0], address[10:3], data[18:11], zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_data[7:0], status[9:8], zeros
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int AW = $clog2(WORDS);

   mwe_pkg::state_type                   state_ff, state_in;
   mwe_pkg::opcode_type                  cmd_op_ff, cmd_op_in;
   logic [mwe_pkg::ADDR_W-1:0]           cmd_addr_ff, cmd_addr_in;
   logic [mwe_pkg::DATA_W-1:0]           cmd_data_ff, cmd_data_in;
   logic                                 we_ff, we_in;
   logic                                 auto_ff;
   logic [AW-1:0]                        cnt_ff, cnt_in;
   logic [WORD_BITS-1:0]                 fill_val_ff, fill_val_in;
   logic                                 rsp_tvalid_ff;
   logic [mwe_pkg::DATA_W-1:0]           rsp_rd_ff, push_rd;
   mwe_pkg::status_type                  rsp_st_ff, push_st;
   logic                                 push;

   logic                                 accept;
   logic                                 slot_free;
   logic                                 in_range;
   logic                                 allowed;
   logic                                 cnt_last;
   logic [15:0]                          req_addr_ext, cmd_addr_ext;
   logic [AW-1:0]                        cmd_idx;

   logic                                 wr_en;
   logic [AW-1:0]                        wr_addr;
   logic [WORD_BITS-1:0]                 wr_data;
   logic [WORD_BITS-1:0]                 rd_data;

   assign req_tready   = (state_ff == mwe_pkg::S_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign slot_free    = !rsp_tvalid_ff || rsp_tready;
   assign req_addr_ext = {8'd0, req_tdata[10:3]};
   assign cmd_addr_ext = {8'd0, cmd_addr_ff};
   assign cmd_idx      = cmd_addr_ext[AW-1:0];
   assign in_range     = {24'd0, cmd_addr_ff} < WORDS;
   assign allowed      = auto_ff || we_ff;
   assign cnt_last     = (cnt_ff == AW'(WORDS - 1));

   mwe_store #(
      .WORDS     (WORDS),
      .WORD_BITS (WORD_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr_ext[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      cmd_op_in   = cmd_op_ff;
      cmd_addr_in = cmd_addr_ff;
      cmd_data_in = cmd_data_ff;
      we_in       = we_ff;
      cnt_in      = cnt_ff;
      fill_val_in = fill_val_ff;
      push        = 1'b0;
      push_rd     = '0;
      push_st     = mwe_pkg::ST_DONE;
      wr_en       = 1'b0;
      wr_addr     = cnt_ff;
      wr_data     = fill_val_ff;

      unique case (state_ff)
         mwe_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '1;
            cnt_in  = cnt_ff + AW'(1);
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = mwe_pkg::S_IDLE;
            end
         end
         mwe_pkg::S_IDLE: begin
            if (accept) begin
               cmd_op_in   = mwe_pkg::opcode_type'(req_tdata[2:0]);
               cmd_addr_in = req_tdata[10:3];
               cmd_data_in = req_tdata[18:11];
               state_in    = mwe_pkg::S_EXEC;
            end
         end
         mwe_pkg::S_EXEC: begin
            if (slot_free) begin
               push     = 1'b1;
               state_in = mwe_pkg::S_IDLE;
               unique case (cmd_op_ff) inside
                  mwe_pkg::OP_READ: begin
                     if (in_range) begin
                        push_rd = rd_data[mwe_pkg::DATA_W-1:0];
                     end else begin
                        push_st = mwe_pkg::ST_RANGE;
                     end
                  end
                  mwe_pkg::OP_ENABLE: begin
                     we_in = 1'b1;
                  end
                  mwe_pkg::OP_DISABLE: begin
                     we_in = 1'b0;
                  end
                  mwe_pkg::OP_WRITE, mwe_pkg::OP_ERASE: begin
                     if (!in_range) begin
                        push_st = mwe_pkg::ST_RANGE;
                     end else if (!allowed) begin
                        push_st = mwe_pkg::ST_DISABLED;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = cmd_idx;
                        wr_data = (cmd_op_ff == mwe_pkg::OP_WRITE) ?
                                  WORD_BITS'(cmd_data_ff) : '1;
                        if (auto_ff) begin
                           we_in = 1'b0;
                        end
                     end
                  end
                  mwe_pkg::OP_ERASE_ALL, mwe_pkg::OP_WRITE_ALL: begin
                     if (!allowed) begin
                        push_st = mwe_pkg::ST_DISABLED;
                     end else begin
                        push        = 1'b0;
                        state_in    = mwe_pkg::S_FILL;
                        cnt_in      = '0;
                        fill_val_in = (cmd_op_ff == mwe_pkg::OP_WRITE_ALL) ?
                                      WORD_BITS'(cmd_data_ff) : '1;
                        if (auto_ff) begin
                           we_in = 1'b0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         mwe_pkg::S_FILL: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + AW'(1);
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = mwe_pkg::S_POST;
            end
         end
         mwe_pkg::S_POST: begin
            if (slot_free) begin
               push     = 1'b1;
               state_in = mwe_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mwe_pkg::S_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mwe_pkg::S_CLEAR;
         cnt_ff        <= '0;
         we_ff         <= 1'b0;
         auto_ff       <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         we_ff    <= we_in;
         if (csr_wr_en) begin
            auto_ff <= csr_wr_data;
         end
         if (push) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_op_ff   <= cmd_op_in;
      cmd_addr_ff <= cmd_addr_in;
      cmd_data_ff <= cmd_data_in;
      fill_val_ff <= fill_val_in;
      if (push) begin
         rsp_rd_ff <= push_rd;
         rsp_st_ff <= push_st;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'd0, rsp_st_ff, rsp_rd_ff};

   // sequencer checks
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == mwe_pkg::S_EXEC)
      else $error("accepted command did not move to execute");

   a_fill_post: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mwe_pkg::S_FILL && cnt_last) |=> state_ff == mwe_pkg::S_POST)
      else $error("bulk sweep did not end in post state");

   a_push_source: assert property (@(posedge clock) disable iff (reset)
      push |-> (state_ff == mwe_pkg::S_EXEC || state_ff == mwe_pkg::S_POST) && slot_free)
      else $error("result pushed from wrong state or into full slot");

endmodule

/* src/mwe_store.sv */
// ----------------------------------------------------------------------------
// mwe_store
// word store: one write port, one registered read port
// ----------------------------------------------------------------------------
module mwe_store #(
   parameter int WORDS     = mwe_pkg::WORDS_DEFAULT,
   parameter int WORD_BITS = mwe_pkg::WORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(WORDS)-1:0] wr_addr,
   input  logic [WORD_BITS-1:0]     wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(WORDS)-1:0] rd_addr,
   output logic [WORD_BITS-1:0]     rd_data
);

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* verif/tb_microwire_eeprom_x8_top.sv */
// ----------------------------------------------------------------------------
// tb_microwire_eeprom_x8_top
// self-checking testbench for the microwire x8 eeprom command model
// ----------------------------------------------------------------------------
// Commands are driven on the req_ stream and every response word on the rsp_
// stream is checked against a behavioural copy of the word store and the
// write-enable latch. A directed pass covers the address and data extremes,
// every opcode, the range check ahead of the disabled check and the unused
// opcode. Random passes then run with auto-enable on and off, under four
// idling patterns on both sides, and a long receiver hold-off fills the
// block until it stalls its input.
// ----------------------------------------------------------------------------
module tb_microwire_eeprom_x8_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          WORDS       = mwe_pkg::WORDS_DEFAULT;
   localparam int          AW          = $clog2(WORDS);
   localparam int          CYCLE_LIMIT = 1_500_000;
   localparam int          HOLD_CYCLES = 400;
   localparam int          PHASE_ITEMS = 225;
   localparam logic [2:0]  OP_UNUSED   = 3'd7;

   typedef struct packed {
      logic [7:0]          read_data;
      mwe_pkg::status_type status;
   } rsp_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en;
   logic        csr_wr_data;

   logic [7:0]   word_mem [0:WORDS-1];
   logic         latch_on;
   logic         auto_on;
   rsp_word_type pending_responses [$];
   rsp_word_type want;

   int          errors = 0;
   int          cycle_count = 0;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_requests;
   int          hold_served = 0;
   int          hold_left = 0;

   microwire_eeprom_x8_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic rsp_word_type eeprom_response(logic [2:0] op, logic [7:0] addr,
                                                    logic [7:0] data);
      rsp_word_type r;
      logic         in_range;
      r.read_data = 8'h00;
      r.status    = mwe_pkg::ST_DONE;
      in_range    = addr < WORDS;
      case (op)
         mwe_pkg::OP_READ: begin
            if (in_range) r.read_data = word_mem[addr[AW-1:0]];
            else r.status = mwe_pkg::ST_RANGE;
         end
         mwe_pkg::OP_ENABLE:  latch_on = 1'b1;
         mwe_pkg::OP_DISABLE: latch_on = 1'b0;
         mwe_pkg::OP_WRITE, mwe_pkg::OP_ERASE, mwe_pkg::OP_ERASE_ALL,
         mwe_pkg::OP_WRITE_ALL: begin
            if ((op == mwe_pkg::OP_WRITE || op == mwe_pkg::OP_ERASE) && !in_range) begin
               r.status = mwe_pkg::ST_RANGE;
            end else begin
               if (auto_on) latch_on = 1'b1;
               if (!latch_on) begin
                  r.status = mwe_pkg::ST_DISABLED;
               end else begin
                  case (op)
                     mwe_pkg::OP_WRITE:     word_mem[addr[AW-1:0]] = data;
                     mwe_pkg::OP_ERASE:     word_mem[addr[AW-1:0]] = 8'hFF;
                     mwe_pkg::OP_ERASE_ALL:
                        for (int i = 0; i < WORDS; i++) word_mem[i] = 8'hFF;
                     default:
                        for (int i = 0; i < WORDS; i++) word_mem[i] = data;
                  endcase
                  if (auto_on) latch_on = 1'b0;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int wanted);
      $display("mismatch %s: got %0h, wanted %0h at cycle %0d", what, got, wanted,
               cycle_count);
      errors++;
   endtask

   task automatic send_cmd(logic [2:0] op, logic [7:0] addr, logic [7:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, data, addr, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_responses.push_back(eeprom_response(op, addr, data));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic set_auto(logic v);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      auto_on = v;
   endtask

   task automatic set_idle_phase(int p);
      case (p)
         0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
         default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
   endtask

   function automatic logic [7:0] rand_addr();
      if ($urandom_range(9) == 0) return 8'($urandom_range(255, WORDS));
      return 8'($urandom_range(WORDS - 1));
   endfunction

   task automatic send_random_cmd();
      int         r;
      logic [2:0] op;
      r = $urandom_range(99);
      if (r < 35)      op = mwe_pkg::OP_READ;
      else if (r < 60) op = mwe_pkg::OP_WRITE;
      else if (r < 75) op = mwe_pkg::OP_ERASE;
      else if (r < 77) op = mwe_pkg::OP_ERASE_ALL;
      else if (r < 79) op = mwe_pkg::OP_WRITE_ALL;
      else if (r < 88) op = mwe_pkg::OP_ENABLE;
      else if (r < 97) op = mwe_pkg::OP_DISABLE;
      else             op = OP_UNUSED;
      send_cmd(op, rand_addr(), 8'($urandom_range(255)));
   endtask

   task automatic test_directed();
      set_auto(1'b1);
      send_cmd(mwe_pkg::OP_READ, 8'd0, 8'h00);
      send_cmd(mwe_pkg::OP_READ, 8'd127, 8'hFF);
      send_cmd(mwe_pkg::OP_READ, 8'd128, 8'h00);
      send_cmd(mwe_pkg::OP_READ, 8'd255, 8'hFF);
      send_cmd(mwe_pkg::OP_WRITE, 8'd0, 8'h00);
      send_cmd(mwe_pkg::OP_WRITE, 8'd127, 8'hFF);
      send_cmd(mwe_pkg::OP_WRITE, 8'd64, 8'hA5);
      send_cmd(mwe_pkg::OP_READ, 8'd0, 8'h00);
      send_cmd(mwe_pkg::OP_READ, 8'd64, 8'h00);
      send_cmd(mwe_pkg::OP_WRITE, 8'd128, 8'h5A);
      send_cmd(mwe_pkg::OP_ERASE, 8'd64, 8'h00);
      send_cmd(mwe_pkg::OP_READ, 8'd64, 8'h00);
      send_cmd(mwe_pkg::OP_ERASE, 8'd255, 8'h00);
      send_cmd(mwe_pkg::OP_WRITE_ALL, 8'd255, 8'h3C);
      send_cmd(mwe_pkg::OP_READ, 8'd127, 8'h00);
      send_cmd(mwe_pkg::OP_ERASE_ALL, 8'd200, 8'h77);
      send_cmd(mwe_pkg::OP_READ, 8'd0, 8'h00);
      send_cmd(OP_UNUSED, 8'd255, 8'hFF);
      // latch off, auto-enable off: range check wins over disabled
      set_auto(1'b0);
      send_cmd(mwe_pkg::OP_WRITE, 8'd5, 8'h11);
      send_cmd(mwe_pkg::OP_WRITE, 8'd200, 8'h22);
      send_cmd(mwe_pkg::OP_ERASE_ALL, 8'd0, 8'h00);
      send_cmd(mwe_pkg::OP_ENABLE, 8'd255, 8'hFF);
      send_cmd(mwe_pkg::OP_WRITE, 8'd5, 8'h11);
      send_cmd(mwe_pkg::OP_READ, 8'd5, 8'h00);
      send_cmd(mwe_pkg::OP_DISABLE, 8'd0, 8'h00);
      send_cmd(mwe_pkg::OP_ERASE, 8'd5, 8'h00);
      wait_drained();
   endtask

   task automatic test_manual_enable();
      int sent;
      int n;
      set_auto(1'b0);
      for (int p = 0; p < 4; p++) begin
         set_idle_phase(p);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // mostly enable .. commands .. disable, sometimes broken
            if ($urandom_range(9) != 0) begin
               send_cmd(mwe_pkg::OP_ENABLE, rand_addr(), 8'($urandom_range(255)));
               sent++;
            end
            n = $urandom_range(8, 1);
            repeat (n) send_random_cmd();
            sent += n;
            if ($urandom_range(9) != 0) begin
               send_cmd(mwe_pkg::OP_DISABLE, rand_addr(), 8'($urandom_range(255)));
               sent++;
            end
         end
         wait_drained();
      end
   endtask

   task automatic test_auto_enable();
      set_auto(1'b1);
      for (int p = 0; p < 4; p++) begin
         set_idle_phase(p);
         repeat (PHASE_ITEMS) send_random_cmd();
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      set_idle_phase(0);
      hold_requests++;
      repeat (8) send_random_cmd();
      send_cmd(mwe_pkg::OP_WRITE_ALL, 8'd0, 8'h96);
      repeat (8) send_random_cmd();
      wait_drained();
   endtask

   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tdata[7:0] !== want.read_data)
               report_mismatch("read_data", rsp_tdata[7:0], want.read_data);
            if (rsp_tdata[9:8] !== want.status)
               report_mismatch("status", rsp_tdata[9:8], want.status);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests  = 0;
      latch_on       = 1'b0;
      auto_on        = 1'b1;
      for (int i = 0; i < WORDS; i++) word_mem[i] = 8'hFF;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_manual_enable();
      test_auto_enable();
      test_backpressure();

      wait_drained();
      repeat (WORDS + 8) @(posedge clock);
      if (errors == 0 && pending_responses.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
